@@ design/ssr_pkg.sv @@
// ----------------------------------------------------------------------------
// ssr_pkg
// Shared types and constants for the subset-sum reachability block.
// ----------------------------------------------------------------------------
package ssr_pkg;

	localparam int ELEM_W   = 16;  // element_value width
	localparam int TARGET_W = 10;  // target_sum width
	localparam int WORD_W   = 64;  // bitmap word width
	localparam int BIT_W    = 6;   // bit position inside a word
	localparam int WSH_W    = ELEM_W - BIT_W;  // word offset of an element
	localparam int SADDR_W  = 12;  // signed source word address
	localparam int OUT_W    = 8;   // m_tdata width

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PRIME,
		ST_RUN,
		ST_DRAIN,
		ST_CHECK,
		ST_RESULT
	} ssr_state_t;

endpackage

@@ design/subset_sum_reachability.sv @@
// ----------------------------------------------------------------------------
// subset_sum_reachability
// Decides whether some subset of a stream of elements sums to target_sum,
// by shift-or updates of a reachable-sum bitmap, one word per cycle.
// ----------------------------------------------------------------------------
// channel | dir | handshake        | payload
// s_      | in  | tvalid / tready  | tdata[15:0] element_value, tlast last_element
// m_      | out | tvalid / tready  | tdata[7:0] subset_found in bit 0
// cfg_    | in  | wr_en            | wr_data[9:0] target_sum
//
// an element in 1..MAX_TARGET makes a pass through the prime, run and drain
// states: one word of the bitmap store is read, shift-ored and written per cycle.
// zero or out-of-range elements need no pass; a last element adds the check
// and result states for the target lookup before the result is offered.
// reset leaves only sum zero reachable and target_sum at zero; the map is
// cleared through per-word valid bits.
// a stalled result holds back the next last element only.
// ----------------------------------------------------------------------------
module subset_sum_reachability #(
	parameter int MAX_TARGET = 1023
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [ssr_pkg::ELEM_W-1:0]   s_tdata,   // element_value
	input  logic                         s_tlast,   // last_element
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [ssr_pkg::OUT_W-1:0]    m_tdata,   // [0] subset_found, rest zero
	input  logic                         cfg_wr_en,
	input  logic [ssr_pkg::TARGET_W-1:0] cfg_wr_data  // target_sum
);
	import ssr_pkg::*;

	localparam int WORDS    = MAX_TARGET / 64 + 1;
	localparam int ADDR_W   = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int TOP_BITS = MAX_TARGET % 64 + 1;
	localparam logic [WORD_W-1:0] TOP_MASK =
		(TOP_BITS == 64) ? {WORD_W{1'b1}} : ((64'd1 << (TOP_BITS % 64)) - 64'd1);
	localparam logic [ADDR_W-1:0] LAST_WORD = ADDR_W'(WORDS - 1);

	ssr_state_t state_q, state_d;

	logic [TARGET_W-1:0] target_q;
	logic [WSH_W-1:0]    ws_q;
	logic [BIT_W-1:0]    bs_q;
	logic                last_q;
	logic [ADDR_W-1:0]   i_q;
	logic [WORD_W-1:0]   upper_q;
	logic                wr_s1;
	logic                prime_s1;
	logic                b_neg_s1;
	logic [ADDR_W-1:0]   wr_addr_s1;
	logic                found_q;
	logic                out_valid_q;

	logic                accept;
	logic                skip;
	logic [SADDR_W-1:0]  upper_addr;
	logic [SADDR_W-1:0]  lower_addr;
	logic                rd_a_en;
	logic [ADDR_W-1:0]   rd_a_addr;
	logic                rd_b_en;
	logic [ADDR_W-1:0]   rd_b_addr;
	logic                b_neg;
	logic                issue_run;
	logic                issue_prime;
	logic                load_out;
	logic                found_d;
	logic [WORD_W-1:0]   rd_a_data;
	logic [WORD_W-1:0]   rd_b_data;
	logic [WORD_W-1:0]   lower_val;
	logic [WORD_W-1:0]   keep_mask;
	logic [WORD_W-1:0]   new_word;

	assign accept     = s_tvalid && s_tready;
	assign skip       = (s_tdata == '0) || (s_tdata > ELEM_W'(MAX_TARGET));
	// source word addresses, negative means below the map
	assign upper_addr = SADDR_W'(WORDS - 1) - SADDR_W'(ws_q);
	assign lower_addr = SADDR_W'(i_q) - SADDR_W'(ws_q) - SADDR_W'(1);

	always_comb begin
		state_d     = state_q;
		s_tready    = 1'b0;
		rd_a_en     = 1'b0;
		rd_a_addr   = i_q;
		rd_b_en     = 1'b0;
		rd_b_addr   = lower_addr[ADDR_W-1:0];
		b_neg       = lower_addr[SADDR_W-1];
		issue_run   = 1'b0;
		issue_prime = 1'b0;
		load_out    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					if (!skip) begin
						state_d = ST_PRIME;
					end else if (s_tlast) begin
						state_d = ST_CHECK;
					end
				end
			end
			ST_PRIME: begin
				rd_b_en     = !upper_addr[SADDR_W-1];
				rd_b_addr   = upper_addr[ADDR_W-1:0];
				b_neg       = upper_addr[SADDR_W-1];
				issue_prime = 1'b1;
				state_d     = ST_RUN;
			end
			ST_RUN: begin
				rd_a_en   = 1'b1;
				rd_b_en   = !lower_addr[SADDR_W-1];
				issue_run = 1'b1;
				if (i_q == '0) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = last_q ? ST_CHECK : ST_IDLE;
			end
			ST_CHECK: begin
				rd_a_en   = 1'b1;
				rd_a_addr = ADDR_W'(target_q >> BIT_W);
				state_d   = ST_RESULT;
			end
			ST_RESULT: begin
				if (!out_valid_q || m_tready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q    <= '0;
			last_q      <= 1'b0;
			i_q         <= '0;
			wr_s1       <= 1'b0;
			prime_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				target_q <= cfg_wr_data;
			end
			if (accept) begin
				last_q <= s_tlast;
				i_q    <= LAST_WORD;
			end else if (issue_run) begin
				i_q <= i_q - ADDR_W'(1);
			end
			wr_s1    <= issue_run;
			prime_s1 <= issue_prime;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ws_q <= s_tdata[ELEM_W-1:BIT_W];
			bs_q <= s_tdata[BIT_W-1:0];
		end
		b_neg_s1   <= b_neg;
		wr_addr_s1 <= i_q;
		// the lower source of this word is the upper source of the next one down
		if (prime_s1 || wr_s1) begin
			upper_q <= lower_val;
		end
		if (load_out) begin
			found_q <= found_d;
		end
	end

	assign lower_val = b_neg_s1 ? '0 : rd_b_data;
	assign keep_mask = (wr_addr_s1 == LAST_WORD) ? TOP_MASK : {WORD_W{1'b1}};

	always_comb begin
		if (target_q == '0) begin
			found_d = 1'b1;
		end else if (ELEM_W'(target_q) > ELEM_W'(MAX_TARGET)) begin
			found_d = 1'b0;
		end else begin
			found_d = rd_a_data[target_q[BIT_W-1:0]];
		end
	end

	ssr_bitmap #(
		.WORDS  (WORDS),
		.ADDR_W (ADDR_W)
	) u_bitmap (
		.clk       (clk),
		.arst_n    (arst_n),
		.clr       (load_out),
		.rd_a_en   (rd_a_en),
		.rd_a_addr (rd_a_addr),
		.rd_a_data (rd_a_data),
		.rd_b_en   (rd_b_en),
		.rd_b_addr (rd_b_addr),
		.rd_b_data (rd_b_data),
		.wr_en     (wr_s1),
		.wr_addr   (wr_addr_s1),
		.wr_data   (new_word)
	);

	ssr_shift_or u_shift_or (
		.dest      (rd_a_data),
		.upper     (upper_q),
		.lower     (lower_val),
		.bit_shift (bs_q),
		.keep_mask (keep_mask),
		.result    (new_word)
	);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_W-1){1'b0}}, found_q};

endmodule

@@ design/ssr_bitmap.sv @@
// ----------------------------------------------------------------------------
// ssr_bitmap
// Reachable-sum word store: one write port, two registered read ports, and a
// valid bit per word so that a clear needs no per-word writes.
// ----------------------------------------------------------------------------
module ssr_bitmap #(
	parameter int WORDS  = 16,
	parameter int ADDR_W = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       clr,
	input  logic                       rd_a_en,
	input  logic [ADDR_W-1:0]          rd_a_addr,
	output logic [ssr_pkg::WORD_W-1:0] rd_a_data,
	input  logic                       rd_b_en,
	input  logic [ADDR_W-1:0]          rd_b_addr,
	output logic [ssr_pkg::WORD_W-1:0] rd_b_data,
	input  logic                       wr_en,
	input  logic [ADDR_W-1:0]          wr_addr,
	input  logic [ssr_pkg::WORD_W-1:0] wr_data
);
	import ssr_pkg::*;

	logic [WORD_W-1:0] mem [WORDS];
	logic [WORDS-1:0]  valid_q;
	logic [WORD_W-1:0] a_q;
	logic [WORD_W-1:0] b_q;
	logic              a_valid_q;
	logic              a_zero_q;
	logic              b_valid_q;
	logic              b_zero_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_a_en) begin
			a_q <= mem[rd_a_addr];
		end
		if (rd_b_en) begin
			b_q <= mem[rd_b_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			a_valid_q <= 1'b0;
			a_zero_q  <= 1'b0;
			b_valid_q <= 1'b0;
			b_zero_q  <= 1'b0;
		end else begin
			if (clr) begin
				valid_q <= '0;
			end else if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_a_en) begin
				a_valid_q <= valid_q[rd_a_addr];
				a_zero_q  <= (rd_a_addr == '0);
			end
			if (rd_b_en) begin
				b_valid_q <= valid_q[rd_b_addr];
				b_zero_q  <= (rd_b_addr == '0);
			end
		end
	end

	// unwritten words read as the cleared map: only sum zero set
	assign rd_a_data = a_valid_q ? a_q : {{(WORD_W-1){1'b0}}, a_zero_q};
	assign rd_b_data = b_valid_q ? b_q : {{(WORD_W-1){1'b0}}, b_zero_q};

endmodule

@@ design/ssr_shift_or.sv @@
// ----------------------------------------------------------------------------
// ssr_shift_or
// Shared shift-or unit: builds one new bitmap word from the old word and the
// two source words that straddle it.
// ----------------------------------------------------------------------------
module ssr_shift_or (
	input  logic [ssr_pkg::WORD_W-1:0] dest,
	input  logic [ssr_pkg::WORD_W-1:0] upper,
	input  logic [ssr_pkg::WORD_W-1:0] lower,
	input  logic [ssr_pkg::BIT_W-1:0]  bit_shift,
	input  logic [ssr_pkg::WORD_W-1:0] keep_mask,
	output logic [ssr_pkg::WORD_W-1:0] result
);
	import ssr_pkg::*;

	logic [WORD_W-1:0] up_part;
	logic [WORD_W-1:0] lo_part;
	logic [BIT_W:0]    lo_shift;

	always_comb begin
		lo_shift = 7'd64 - {1'b0, bit_shift};
		up_part  = upper << bit_shift;
		// with no bit shift the lower word contributes nothing
		lo_part  = (bit_shift == '0) ? '0 : (lower >> lo_shift);
		result   = (dest | up_part | lo_part) & keep_mask;
	end

endmodule

@@ design/ssr_checker.sv @@
// ----------------------------------------------------------------------------
// ssr_checker
// Port-level checks for the subset-sum reachability block, bound to the top.
// ----------------------------------------------------------------------------
module ssr_checker #(
	parameter int MAX_TARGET = 1023
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         s_tvalid,
	input logic                         s_tready,
	input logic [ssr_pkg::ELEM_W-1:0]   s_tdata,
	input logic                         s_tlast,
	input logic                         m_tvalid,
	input logic                         m_tready,
	input logic [ssr_pkg::OUT_W-1:0]    m_tdata
);
	import ssr_pkg::*;

	logic s_acc;
	logic work_item;

	assign s_acc     = s_tvalid && s_tready;
	assign work_item = (s_tdata != '0) && (s_tdata <= ELEM_W'(MAX_TARGET));

	// a stalled result stays offered
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	// an element inside the map range occupies the shift-or unit
	a_busy_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc && work_item |=> !s_tready)
		else $error("ready right after an element that needs a pass");

	// a new result is only produced during the target lookup
	a_result_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result appeared while idle");

	// padding bits of the result stay zero
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[OUT_W-1:1] == '0))
		else $error("result padding not zero");

	// a last item that needs no pass goes straight to the target lookup
	a_busy_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc && s_tlast && !work_item |=> !s_tready)
		else $error("ready right after a last element");

endmodule

bind subset_sum_reachability ssr_checker #(.MAX_TARGET(MAX_TARGET)) u_ssr_checker (.*);
